@@ src/lru_key_value_cache_macros.svh @@
// Assertion macros for the key/value cache checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lkvc_pkg.sv @@
// Shared types, constants and helpers for the key/value cache.
// No dependencies; used by every module of the block.
package lkvc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CFG_W        = 7;
  localparam int OCC_W        = 7;
  localparam int CNT_W        = 32;
  localparam int NODE_W       = 32;
  localparam int MODE_W       = 8;
  localparam int BUCKET_W     = 16;
  localparam int ROUTE_W      = 32;
  localparam int ACT_W        = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_RST_CNT = 2'd3
  } act_t;

  typedef struct packed {
    logic [NODE_W-1:0]   origin;
    logic [NODE_W-1:0]   dest;
    logic [MODE_W-1:0]   mode;
    logic [BUCKET_W-1:0] bucket;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic [ROUTE_W-1:0] route;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic capture;    // latch the compare result against the incoming key
    logic shift;      // move entries one place down the chain
    logic shift_all;  // shift the whole chain, not just up to the hit
    logic evict;      // drop the tail entry while shifting
    logic clear;      // invalidate every cell
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ src/lkvc_cell.sv @@
// One cache cell: an entry, its valid bit and a registered key match.
// Depends on lkvc_pkg; chained by lru_key_value_cache, position = recency.
module lkvc_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkvc_pkg::cell_ctl_t ctl,
  input  lkvc_pkg::key_t     cmp_key,
  input  logic [IW-1:0]      hit_pos,
  input  lkvc_pkg::entry_t   prev_entry,
  input  logic               prev_valid,
  output lkvc_pkg::entry_t   entry_o,
  output logic               valid_o,
  output logic               match_o
);
  import lkvc_pkg::*;

  entry_t entry_r;
  logic   valid_r, valid_nxt;
  logic   match_r, match_nxt;
  logic   load;

  // Take the neighbour's entry on a full shift, or when at or above the hit
  assign load = ctl.shift && (ctl.shift_all || (IW'(IDX) <= hit_pos));

  always_comb begin
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (load) begin
      // the tail cell's entry falls off when evicting
      valid_nxt = prev_valid && !(ctl.evict && !valid_r);
    end else begin
      valid_nxt = valid_r;
    end
  end

  assign match_nxt = ctl.capture ? (valid_r && (entry_r.key == cmp_key)) : match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= prev_entry;
    end
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

@@ src/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-inserted eviction.
// Input channel (in_valid/in_ready): one beat per command - lookup, insert or
// update, clear entries, reset counters - with the key and a route handle.
// Output channel (out_valid/out_ready): one beat per command with hit, route,
// evicted flag, occupancy and the three saturating statistics counters.
// Config: cfg_wr_en/cfg_wr_data write capacity_in_use; write it only while the
// block is idle. Zero acts as one, values above CAPACITY as CAPACITY.
// Operation: at the input beat every cell compares its key against the incoming
// one and registers the match; at commit, once the output register is free, the
// chain of cells shifts (cell 0 is most recent) and the result is registered.
// One command is in flight at a time, so a new beat is taken only after the
// previous command has committed its compare-then-shift pass through the chain.
// Stall: a finished result waits in the output register; the next command is
// still taken and its compare done, and it commits once the register frees.
// Reset (synchronous, rst_n low): all cells invalid, occupancy and counters
// zero, capacity back to 64, no result pending.
module lru_key_value_cache #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CFG_W-1:0]    cfg_wr_data,
  // command channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lkvc_pkg::ACT_W-1:0]    in_action,
  input  logic [lkvc_pkg::NODE_W-1:0]   in_origin_node,
  input  logic [lkvc_pkg::NODE_W-1:0]   in_dest_node,
  input  logic [lkvc_pkg::MODE_W-1:0]   in_travel_mode,
  input  logic [lkvc_pkg::BUCKET_W-1:0] in_time_bucket,
  input  logic [lkvc_pkg::ROUTE_W-1:0]  in_route_handle,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lkvc_pkg::ROUTE_W-1:0]  out_route_out,
  output logic                          out_evicted,
  output logic [lkvc_pkg::OCC_W-1:0]    out_occupancy,
  output logic [lkvc_pkg::CNT_W-1:0]    out_hit_count,
  output logic [lkvc_pkg::CNT_W-1:0]    out_miss_count,
  output logic [lkvc_pkg::CNT_W-1:0]    out_eviction_count
);
  import lkvc_pkg::*;

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  act_t               act_r;
  entry_t             head_r;
  logic [CFG_W-1:0]   cap_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   misses_r, misses_nxt;
  logic [CNT_W-1:0]   evicts_r, evicts_nxt;

  logic               out_valid_r;
  logic               out_hit_r, out_hit_nxt;
  logic [ROUTE_W-1:0] out_route_r, out_route_nxt;
  logic               out_evicted_r, out_evicted_nxt;
  logic [OCC_W-1:0]   out_occ_r;

  cell_ctl_t              ctl;
  key_t                   in_key;
  entry_t                 cell_entry [CAPACITY];
  entry_t                 prev_entry [CAPACITY];
  logic [CAPACITY-1:0]    cell_valid, prev_valid, match_vec;
  logic [IW-1:0]          hit_pos;
  logic [ROUTE_W-1:0]     route_sel;
  logic                   any_hit, accept, commit, evict_cond;
  logic [CMPW-1:0]        cap_eff;

  assign in_key = '{origin: in_origin_node, dest: in_dest_node,
                    mode: in_travel_mode, bucket: in_time_bucket};

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // commit once the output register is empty or being drained
  assign commit   = (state_r == ST_APPLY) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 takes the pending request, cell i takes cell i-1
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_entry[i] = head_r;
      assign prev_valid[i] = 1'b1;
    end else begin : g_link
      assign prev_entry[i] = cell_entry[i-1];
      assign prev_valid[i] = cell_valid[i-1];
    end

    lkvc_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (in_key),
      .hit_pos    (hit_pos),
      .prev_entry (prev_entry[i]),
      .prev_valid (prev_valid[i]),
      .entry_o    (cell_entry[i]),
      .valid_o    (cell_valid[i]),
      .match_o    (match_vec[i])
    );
  end

  // Keys are unique among valid cells, so the match vector is one-hot or zero
  always_comb begin
    hit_pos   = '0;
    route_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_pos   = hit_pos | IW'(i);
        route_sel = route_sel | cell_entry[i].route;
      end
    end
  end

  assign any_hit = |match_vec;

  // Effective capacity: clamp to one .. CAPACITY
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(CAPACITY)) begin
      cap_eff = CMPW'(CAPACITY);
    end else begin
      cap_eff = CMPW'(cap_r);
    end
  end

  assign evict_cond = CMPW'(count_r) >= cap_eff;

  // ---------------------------------------------------------------------------
  // Command decode and statistics
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl             = '0;
    ctl.capture     = accept;
    count_nxt       = count_r;
    hits_nxt        = hits_r;
    misses_nxt      = misses_r;
    evicts_nxt      = evicts_r;
    out_hit_nxt     = 1'b0;
    out_route_nxt   = '0;
    out_evicted_nxt = 1'b0;
    if (commit) begin
      unique case (act_r)
        ACT_LOOKUP: begin
          if (any_hit) begin
            out_hit_nxt   = 1'b1;
            out_route_nxt = route_sel;
            hits_nxt      = sat_inc(hits_r);
          end else begin
            misses_nxt = sat_inc(misses_r);
          end
        end
        ACT_INSERT: begin
          ctl.shift     = 1'b1;
          ctl.shift_all = !any_hit;
          if (!any_hit) begin
            if (evict_cond) begin
              ctl.evict       = 1'b1;
              out_evicted_nxt = 1'b1;
              evicts_nxt      = sat_inc(evicts_r);
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end
        end
        ACT_CLEAR: begin
          ctl.clear = 1'b1;
          count_nxt = '0;
        end
        ACT_RST_CNT: begin
          hits_nxt   = '0;
          misses_nxt = '0;
          evicts_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_APPLY: if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request while the chain works on it; register the result at commit
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r        <= act_t'(in_action);
      head_r.key   <= in_key;
      head_r.route <= in_route_handle;
    end
    if (commit) begin
      out_hit_r     <= out_hit_nxt;
      out_route_r   <= out_route_nxt;
      out_evicted_r <= out_evicted_nxt;
      out_occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_route_out      = out_route_r;
  assign out_evicted        = out_evicted_r;
  assign out_occupancy      = out_occ_r;
  // counters only move at commit, so the live values match the held beat
  assign out_hit_count      = hits_r;
  assign out_miss_count     = misses_r;
  assign out_eviction_count = evicts_r;

endmodule

@@ src/lkvc_checker.sv @@
// Port-level checks for lru_key_value_cache, attached by bind.
// Depends on lkvc_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [lkvc_pkg::ROUTE_W-1:0]  out_route_out,
  input logic                          out_evicted,
  input logic [lkvc_pkg::OCC_W-1:0]    out_occupancy
);
  import lkvc_pkg::*;

  // Hold a stalled result beat
  `LKVC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_route_out) && $stable(out_occupancy) && $stable(out_hit), "result beat changed while stalled")

  // One command in flight: an input beat closes the input port behind it
  `LKVC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while a command is in flight")

  `LKVC_ASSERT_NOW(a_hit_no_evict, out_valid && out_hit, !out_evicted, "hit and eviction in one beat")

  `LKVC_ASSERT_NOW(a_miss_route_zero, out_valid && !out_hit, out_route_out == '0, "route nonzero without a hit")

  `LKVC_ASSERT_NOW(a_occ_bound, out_valid && (CAPACITY <= 127), out_occupancy <= CAPACITY, "occupancy above capacity")

endmodule

bind lru_key_value_cache lkvc_checker #(
  .CAPACITY (CAPACITY)
) u_lkvc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hit       (out_hit),
  .out_route_out (out_route_out),
  .out_evicted   (out_evicted),
  .out_occupancy (out_occupancy)
);

@@ tb/lru_key_value_cache_checker.sv @@
// Result checker for the key/value cache: watches the configuration port and both channels.
// Predicts each result beat from its own copy of the cache and compares field by field.
// Depends on lkvc_pkg for widths, the action codes and the key layout.
module lru_key_value_cache_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [lkvc_pkg::ACT_W-1:0]    in_action,
  input  logic [lkvc_pkg::NODE_W-1:0]   in_origin_node,
  input  logic [lkvc_pkg::NODE_W-1:0]   in_dest_node,
  input  logic [lkvc_pkg::MODE_W-1:0]   in_travel_mode,
  input  logic [lkvc_pkg::BUCKET_W-1:0] in_time_bucket,
  input  logic [lkvc_pkg::ROUTE_W-1:0]  in_route_handle,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_hit,
  input  logic [lkvc_pkg::ROUTE_W-1:0]  out_route_out,
  input  logic                          out_evicted,
  input  logic [lkvc_pkg::OCC_W-1:0]    out_occupancy,
  input  logic [lkvc_pkg::CNT_W-1:0]    out_hit_count,
  input  logic [lkvc_pkg::CNT_W-1:0]    out_miss_count,
  input  logic [lkvc_pkg::CNT_W-1:0]    out_eviction_count,
  output int                            mismatches,
  output int                            awaiting,
  output int                            checked,
  output int                            hits_seen,
  output int                            evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int LINES = CAPACITY_DEF;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic               hit;
    logic [ROUTE_W-1:0] route;
    logic               evicted;
    logic [OCC_W-1:0]   occupancy;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [CNT_W-1:0]   evictions;
  } cache_result_t;

  // Own copy of the cache
  logic [CFG_W-1:0]   cap_setting;
  bit                 line_valid [LINES];
  key_t               line_key   [LINES];
  logic [ROUTE_W-1:0] line_route [LINES];
  int unsigned        line_rank  [LINES];
  int unsigned        line_count;
  logic [CNT_W-1:0]   hit_total, miss_total, evict_total;

  cache_result_t expected_results [$];
  cache_result_t want, got, fresh;

  initial begin
    mismatches     = 0;
    awaiting       = 0;
    checked        = 0;
    hits_seen      = 0;
    evictions_seen = 0;
  end

  function automatic logic [CNT_W-1:0] saturate_up(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int find_line(input key_t k);
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i] && line_key[i] == k) return i;
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted)
      report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, seen, wanted));
  endtask

  // Apply one command to the cache copy and return the result it should give.
  task automatic predict_command(input act_t act, input key_t k,
                                 input logic [ROUTE_W-1:0] handle,
                                 output cache_result_t res);
    int          slot;
    int unsigned old_rank;
    int unsigned limit;
    res = '0;
    case (act)
      ACT_LOOKUP: begin
        slot = find_line(k);
        if (slot >= 0) begin
          res.hit   = 1'b1;
          res.route = line_route[slot];
          hit_total = saturate_up(hit_total);
        end else begin
          miss_total = saturate_up(miss_total);
        end
      end
      ACT_INSERT: begin
        slot = find_line(k);
        if (slot >= 0) begin
          // update: promote to most recent, age only the newer ones
          old_rank = line_rank[slot];
          for (int i = 0; i < LINES; i++) begin
            if (line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
          end
          line_rank[slot]  = 0;
          line_route[slot] = handle;
        end else begin
          limit = (cap_setting == 0) ? 1 :
                  (cap_setting > LINES) ? LINES : cap_setting;
          if (line_count >= limit && line_count > 0) begin
            for (int i = 0; i < LINES; i++) begin
              if (line_valid[i] && line_rank[i] == line_count - 1) begin
                line_valid[i] = 1'b0;
                break;
              end
            end
            line_count--;
            res.evicted = 1'b1;
            evict_total = saturate_up(evict_total);
          end
          slot = -1;
          for (int i = 0; i < LINES; i++) begin
            if (!line_valid[i]) begin
              if (slot < 0) slot = i;
            end else begin
              line_rank[i]++;
            end
          end
          if (slot >= 0) begin
            line_valid[slot] = 1'b1;
            line_key[slot]   = k;
            line_route[slot] = handle;
            line_rank[slot]  = 0;
            line_count++;
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;
        line_count = 0;
      end
      default: begin
        hit_total   = '0;
        miss_total  = '0;
        evict_total = '0;
      end
    endcase
    res.occupancy = line_count[OCC_W-1:0];
    res.hits      = hit_total;
    res.misses    = miss_total;
    res.evictions = evict_total;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_setting = CAP_RESET;
      for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;
      line_count  = 0;
      hit_total   = '0;
      miss_total  = '0;
      evict_total = '0;
      expected_results.delete();
    end else begin
      // compare the output beat first, so a same-edge input beat never pairs with it
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          got  = '{out_hit, out_route_out, out_evicted, out_occupancy,
                   out_hit_count, out_miss_count, out_eviction_count};
          check_field("hit", got.hit, want.hit);
          check_field("route_out", got.route, want.route);
          check_field("evicted", got.evicted, want.evicted);
          check_field("occupancy", got.occupancy, want.occupancy);
          check_field("hit_count", got.hits, want.hits);
          check_field("miss_count", got.misses, want.misses);
          check_field("eviction_count", got.evictions, want.evictions);
          checked++;
          if (want.hit) hits_seen++;
          if (want.evicted) evictions_seen++;
        end
      end
      if (cfg_wr_en) cap_setting = cfg_wr_data;
      if (in_valid && in_ready) begin
        predict_command(act_t'(in_action),
                        key_t'({in_origin_node, in_dest_node, in_travel_mode, in_time_bucket}),
                        in_route_handle, fresh);
        // append at the tail
        expected_results = {expected_results, fresh};
      end
    end
    awaiting = expected_results.size();
  end

endmodule

@@ tb/lru_key_value_cache_tb.sv @@
// Top of the key/value cache regression: clock, reset, command and configuration stimulus.
// Instantiates the block as u_top and lru_key_value_cache_checker beside it; gives the verdict.
// Depends on lkvc_pkg and the block's RTL.
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int POOL_SIZE       = 96;
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 136;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action = ACT_LOOKUP;
  logic [NODE_W-1:0]   in_origin_node = '0;
  logic [NODE_W-1:0]   in_dest_node = '0;
  logic [MODE_W-1:0]   in_travel_mode = '0;
  logic [BUCKET_W-1:0] in_time_bucket = '0;
  logic [ROUTE_W-1:0]  in_route_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic [ROUTE_W-1:0]  out_route_out;
  logic                out_evicted;
  logic [OCC_W-1:0]    out_occupancy;
  logic [CNT_W-1:0]    out_hit_count;
  logic [CNT_W-1:0]    out_miss_count;
  logic [CNT_W-1:0]    out_eviction_count;

  // Checker status
  int mismatches, awaiting, checked, hits_seen, evictions_seen;

  // Stimulus controls
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off_req = 1'b0;
  int   settings_written = 0;
  int   cycle_count = 0;
  key_t key_pool [POOL_SIZE];
  // Capacities per phase: full, above range, lowered below occupancy, zero, and so on
  int   phase_cap [PHASES] = '{64, 127, 1, 0, 2, 64, 96, 3, 33, 16, 8, 64};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lru_key_value_cache u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_origin_node     (in_origin_node),
    .in_dest_node       (in_dest_node),
    .in_travel_mode     (in_travel_mode),
    .in_time_bucket     (in_time_bucket),
    .in_route_handle    (in_route_handle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_route_out      (out_route_out),
    .out_evicted        (out_evicted),
    .out_occupancy      (out_occupancy),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count)
  );

  lru_key_value_cache_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_origin_node     (in_origin_node),
    .in_dest_node       (in_dest_node),
    .in_travel_mode     (in_travel_mode),
    .in_time_bucket     (in_time_bucket),
    .in_route_handle    (in_route_handle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_route_out      (out_route_out),
    .out_evicted        (out_evicted),
    .out_occupancy      (out_occupancy),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .mismatches         (mismatches),
    .awaiting           (awaiting),
    .checked            (checked),
    .hits_seen          (hits_seen),
    .evictions_seen     (evictions_seen)
  );

  // Draw a key with every field fully random.
  function automatic key_t random_key();
    key_t k;
    k.origin = $urandom();
    k.dest   = $urandom();
    k.mode   = MODE_W'($urandom());
    k.bucket = BUCKET_W'($urandom());
    return k;
  endfunction

  // Fill the key pool: the two extreme keys first, then random keys, with every
  // fifth key a copy of its neighbour that differs in one field only, so the
  // compare has to look at every part of the key.
  task automatic build_key_pool();
    key_t k;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      if (i % 5 == 4) begin
        k = key_pool[i-1];
        case ($urandom_range(3))
          0: k.origin = $urandom();
          1: k.dest   = $urandom();
          2: k.mode   = k.mode ^ MODE_W'($urandom_range(255, 1));
          default: k.bucket = k.bucket ^ BUCKET_W'($urandom_range(65535, 1));
        endcase
      end else begin
        k = random_key();
      end
      key_pool[i] = k;
    end
  endtask

  // Offer one command beat and hold it until accepted. A gap, if any, lowers
  // valid first; otherwise valid stays high straight into the next beat.
  task automatic send_cmd(input act_t act, input key_t k, input logic [ROUTE_W-1:0] handle);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_origin_node  <= k.origin;
    in_dest_node    <= k.dest;
    in_travel_mode  <= k.mode;
    in_time_bucket  <= k.bucket;
    in_route_handle <= handle;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every result beat has come back. The count is
  // read at the falling edge so it already reflects the last rising edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register once the block is idle.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= CFG_W'($urandom());
    settings_written++;
  endtask

  // Directed opening: extremes of the key, hit and miss, update of a present
  // key, keys that differ in a single field, counter reset, clear, and the
  // zero capacity that behaves as a capacity of one.
  task automatic run_directed();
    key_t z, o, v;
    z = '0;
    o = '1;
    send_cmd(ACT_LOOKUP, z, '0);                // miss on an empty table
    send_cmd(ACT_INSERT, z, '0);
    send_cmd(ACT_INSERT, o, '1);
    send_cmd(ACT_LOOKUP, z, '1);
    send_cmd(ACT_LOOKUP, o, '0);
    send_cmd(ACT_INSERT, z, 32'h1234_5678);     // update, no eviction
    send_cmd(ACT_LOOKUP, z, '0);
    v = o; v.origin = '0; send_cmd(ACT_LOOKUP, v, '0);
    v = o; v.dest   = '0; send_cmd(ACT_LOOKUP, v, '0);
    v = o; v.mode   = '0; send_cmd(ACT_LOOKUP, v, '0);
    v = o; v.bucket = '0; send_cmd(ACT_LOOKUP, v, '0);
    send_cmd(ACT_RST_CNT, o, '1);               // entries must survive
    send_cmd(ACT_LOOKUP, o, '0);
    send_cmd(ACT_CLEAR, z, '0);                 // counters must survive
    send_cmd(ACT_LOOKUP, o, '0);
    write_capacity('0);
    send_cmd(ACT_INSERT, z, 32'hA5A5_5A5A);
    send_cmd(ACT_INSERT, o, 32'h5A5A_A5A5);     // evicts the only entry
    send_cmd(ACT_LOOKUP, z, '0);
    send_cmd(ACT_LOOKUP, o, '0);
    send_cmd(ACT_INSERT, o, 32'h0F0F_F0F0);     // present key at capacity
    send_cmd(ACT_LOOKUP, o, '0);
    send_cmd(ACT_RST_CNT, z, '0);
  endtask

  // One random command. Keys come mostly from a window of the pool a little
  // wider than the capacity, so lookups hit, updates happen and inserts evict;
  // a few beats carry a fully random key.
  task automatic send_random_cmd(input int eff_cap);
    int   span, r, clear_cut, ins_pct;
    act_t act;
    key_t k;
    span      = (eff_cap + 6 < POOL_SIZE) ? eff_cap + 6 : POOL_SIZE;
    clear_cut = (eff_cap <= 16) ? 20 : 3;
    ins_pct   = (eff_cap >= 33) ? 62 : 45;
    k = key_pool[$urandom_range(span - 1)];
    r = $urandom_range(999);
    if (r < clear_cut) begin
      act = ACT_CLEAR;
    end else if (r < clear_cut + 20) begin
      act = ACT_RST_CNT;
    end else begin
      act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_LOOKUP;
      if (r >= 960) k = random_key();
    end
    send_cmd(act, k, $urandom());
  endtask

  // Result side: random back-pressure, plus one long hold-off on request while
  // the command side keeps offering beats, so the block fills and stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: advance a cycle count and end the run if it reaches the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, awaiting);
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

  initial begin
    build_key_pool();
    phase_cap[PHASES-1] = $urandom_range(60, 4);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CFG_W'(phase_cap[p]));
      // rotate through the idling patterns: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (p == 4) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_cmd((phase_cap[p] == 0) ? 1 :
                        (phase_cap[p] > CAPACITY_DEF) ? CAPACITY_DEF : phase_cap[p]);
      end
    end

    drain();
    $display("Checked %0d result beats over %0d capacity settings (zero and above range included).",
             checked, settings_written);
    $display("Saw %0d lookup hits and %0d evictions, with a %0d-cycle result hold-off.",
             hits_seen, evictions_seen, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule
